// ===== rtl/core/cfr_pkg.sv =====
// Types and constants shared by the configuration frame receiver files.
package cfr_pkg;

    localparam int N_PAYLOAD = 7;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_pos;
    typedef logic [7:0] t_pins;
    typedef t_byte [N_PAYLOAD-1:0] t_payload;

    localparam t_byte HDR_BYTE  = 8'hAA;
    localparam t_byte SYNC_BYTE = 8'hDD;
    localparam t_byte CODE_ZERO = 8'h00;
    localparam t_byte CODE_ONE  = 8'h01;

    localparam t_byte MODE_OFF  = 8'h00;
    localparam t_byte MODE_SYNC = 8'h01;
    localparam t_byte MODE_SVP  = 8'h02;

    localparam t_pos POS_HUNT      = 4'd0;
    localparam t_pos POS_HDR       = 4'd1;
    localparam t_pos POS_FIRST     = 4'd2;
    localparam t_pos POS_TAIL      = 4'd9;
    localparam t_pos FRAME_LEN     = 4'd10;

    localparam int IDX_HEADING = 0;
    localparam int IDX_MOTION  = 1;
    localparam int IDX_GNSS    = 2;
    localparam int IDX_PPS     = 3;
    localparam int IDX_MODE    = 4;
    localparam int IDX_SVP     = 5;
    localparam int IDX_SYNC    = 6;

    localparam int PIN_HEADING = 0;
    localparam int PIN_MOTION  = 1;
    localparam int PIN_GNSS    = 2;
    localparam int PIN_PPS     = 3;
    localparam int PIN_TTL     = 4;
    localparam int PIN_SVP     = 5;
    localparam int PIN_SD      = 6;
    localparam int PIN_DIR     = 7;

    localparam t_pins PIN_RESET = 8'hE8;

    typedef struct packed {
        logic     tail;
        logic     good;
        t_payload payload;
    } t_frame_evt;

endpackage

// ===== rtl/core/cfr_byte_if.sv =====
// Request channel that carries one received configuration byte.
interface cfr_byte_if;
    logic          valid;
    logic          ready;
    cfr_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/cfr_result_if.sv =====
// Request channel that carries the pin levels and status of one completed frame.
interface cfr_result_if;
    logic valid;
    logic ready;
    logic heading_sel;
    logic motion_sel;
    logic gnss_sel;
    logic pps_sel;
    logic ttl_switch;
    logic svp_iface;
    logic sync_sd_pin;
    logic sync_dir_pin;
    logic frame_status;

    modport source (
        output valid, input ready,
        output heading_sel, output motion_sel, output gnss_sel, output pps_sel,
        output ttl_switch, output svp_iface, output sync_sd_pin, output sync_dir_pin,
        output frame_status
    );
    modport sink (
        input valid, output ready,
        input heading_sel, input motion_sel, input gnss_sel, input pps_sel,
        input ttl_switch, input svp_iface, input sync_sd_pin, input sync_dir_pin,
        input frame_status
    );
endinterface

// ===== rtl/core/cfr_frame.sv =====
// Frame position tracker and setting byte store.
module cfr_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  cfr_pkg::t_byte      i_byte,
    output cfr_pkg::t_frame_evt o_evt
);

    cfr_pkg::t_pos     r_pos;
    cfr_pkg::t_pos     n_pos;
    cfr_pkg::t_payload r_payload;
    logic [2:0]        wr_off;
    logic              wr_en;
    logic              tail;
    logic              good;

    assign wr_off = 3'(r_pos - cfr_pkg::POS_FIRST);

    always_comb begin
        n_pos = r_pos;
        wr_en = 1'b0;
        tail  = 1'b0;
        good  = 1'b0;
        if (r_pos == cfr_pkg::POS_HUNT || r_pos >= cfr_pkg::FRAME_LEN) begin
            n_pos = (i_byte == cfr_pkg::HDR_BYTE) ? cfr_pkg::POS_HDR : cfr_pkg::POS_HUNT;
        end else if (r_pos == cfr_pkg::POS_HDR) begin
            n_pos = (i_byte == cfr_pkg::SYNC_BYTE) ? cfr_pkg::POS_FIRST : cfr_pkg::POS_HUNT;
        end else if (r_pos < cfr_pkg::POS_TAIL) begin
            n_pos = r_pos + 4'd1;
            wr_en = 1'b1;
        end else begin
            n_pos = cfr_pkg::POS_HUNT;
            tail  = 1'b1;
            good  = (i_byte == cfr_pkg::SYNC_BYTE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= cfr_pkg::POS_HUNT;
        end else if (i_fire) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && wr_en) begin
            r_payload[wr_off] <= i_byte;
        end
    end

    assign o_evt.tail    = tail;
    assign o_evt.good    = good;
    assign o_evt.payload = r_payload;

endmodule

// ===== rtl/core/cfr_pins.sv =====
// Held pin levels and the decoding of the setting bytes into them.
module cfr_pins (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  cfr_pkg::t_frame_evt i_evt,
    output cfr_pkg::t_pins      o_next
);

    cfr_pkg::t_pins   r_pins;
    cfr_pkg::t_pins   n_pins;
    cfr_pkg::t_byte   mode;
    logic             apply;

    assign mode  = i_evt.payload[cfr_pkg::IDX_MODE];
    assign apply = i_evt.tail && i_evt.good;

    always_comb begin
        n_pins = r_pins;
        if (i_evt.payload[cfr_pkg::IDX_HEADING] == cfr_pkg::CODE_ZERO) begin
            n_pins[cfr_pkg::PIN_HEADING] = 1'b0;
        end else if (i_evt.payload[cfr_pkg::IDX_HEADING] == cfr_pkg::CODE_ONE) begin
            n_pins[cfr_pkg::PIN_HEADING] = 1'b1;
        end
        if (i_evt.payload[cfr_pkg::IDX_MOTION] == cfr_pkg::CODE_ZERO) begin
            n_pins[cfr_pkg::PIN_MOTION] = 1'b0;
        end else if (i_evt.payload[cfr_pkg::IDX_MOTION] == cfr_pkg::CODE_ONE) begin
            n_pins[cfr_pkg::PIN_MOTION] = 1'b1;
        end
        if (i_evt.payload[cfr_pkg::IDX_GNSS] == cfr_pkg::CODE_ZERO) begin
            n_pins[cfr_pkg::PIN_GNSS] = 1'b0;
        end else if (i_evt.payload[cfr_pkg::IDX_GNSS] == cfr_pkg::CODE_ONE) begin
            n_pins[cfr_pkg::PIN_GNSS] = 1'b1;
        end
        if (i_evt.payload[cfr_pkg::IDX_PPS] == cfr_pkg::CODE_ZERO) begin
            n_pins[cfr_pkg::PIN_PPS] = 1'b0;
        end else if (i_evt.payload[cfr_pkg::IDX_PPS] == cfr_pkg::CODE_ONE) begin
            n_pins[cfr_pkg::PIN_PPS] = 1'b1;
        end
        case (mode)
            cfr_pkg::MODE_OFF: begin
                n_pins[cfr_pkg::PIN_TTL] = 1'b1;
            end
            cfr_pkg::MODE_SYNC: begin
                n_pins[cfr_pkg::PIN_TTL] = 1'b0;
                if (i_evt.payload[cfr_pkg::IDX_SYNC] == cfr_pkg::CODE_ONE) begin
                    n_pins[cfr_pkg::PIN_SD]  = 1'b0;
                    n_pins[cfr_pkg::PIN_DIR] = 1'b1;
                end else begin
                    n_pins[cfr_pkg::PIN_SD]  = 1'b1;
                    n_pins[cfr_pkg::PIN_DIR] = 1'b0;
                end
            end
            cfr_pkg::MODE_SVP: begin
                n_pins[cfr_pkg::PIN_TTL] = 1'b1;
                if (i_evt.payload[cfr_pkg::IDX_SVP] == cfr_pkg::CODE_ZERO) begin
                    n_pins[cfr_pkg::PIN_SVP] = 1'b1;
                end else if (i_evt.payload[cfr_pkg::IDX_SVP] == cfr_pkg::CODE_ONE) begin
                    n_pins[cfr_pkg::PIN_SVP] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins <= cfr_pkg::PIN_RESET;
        end else if (i_fire && apply) begin
            r_pins <= n_pins;
        end
    end

    assign o_next = apply ? n_pins : r_pins;

endmodule

// ===== rtl/core/config_frame_receiver_pin_driver_core.sv =====
// Top level of the configuration frame receiver and interface-select pin driver.
//
//   channel   direction   payload                              per request
//   i_rx      in          rx_byte                              one stream byte
//   o_res     out         eight pin levels, frame_status       one completed frame
//
// Each byte is registered on entry and then handled by the frame tracker and pin
// decoder, one byte per cycle sustained while no tail byte waits on a stalled result.
// A result is registered in the output register when its tail byte is handled.
// Reset is synchronous: hunting for the header, pins at their default levels.
// Only a tail byte waiting on a full, stalled output register holds back input.
module config_frame_receiver_pin_driver_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cfr_byte_if.sink             i_rx,
    cfr_result_if.source         o_res
);

    logic                r_in_valid;
    cfr_pkg::t_byte      r_in_byte;
    logic                r_out_valid;
    cfr_pkg::t_pins      r_out_pins;
    logic                r_out_status;
    cfr_pkg::t_frame_evt evt;
    cfr_pkg::t_pins      next_pins;
    logic                advance;

    assign advance    = r_in_valid && !(evt.tail && r_out_valid && !o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    cfr_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_byte  (r_in_byte),
        .o_evt   (evt)
    );

    cfr_pins u_pins (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_evt   (evt),
        .o_next  (next_pins)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && evt.tail) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && evt.tail) begin
            r_out_pins   <= next_pins;
            r_out_status <= !evt.good;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.heading_sel  = r_out_pins[cfr_pkg::PIN_HEADING];
    assign o_res.motion_sel   = r_out_pins[cfr_pkg::PIN_MOTION];
    assign o_res.gnss_sel     = r_out_pins[cfr_pkg::PIN_GNSS];
    assign o_res.pps_sel      = r_out_pins[cfr_pkg::PIN_PPS];
    assign o_res.ttl_switch   = r_out_pins[cfr_pkg::PIN_TTL];
    assign o_res.svp_iface    = r_out_pins[cfr_pkg::PIN_SVP];
    assign o_res.sync_sd_pin  = r_out_pins[cfr_pkg::PIN_SD];
    assign o_res.sync_dir_pin = r_out_pins[cfr_pkg::PIN_DIR];
    assign o_res.frame_status = r_out_status;

endmodule

// ===== rtl/core/cfr_checker.sv =====
// Port checker for the configuration frame receiver, bound to the top level.
module cfr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rx_valid,
    input logic i_rx_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_res_status,
    input logic [7:0] i_res_pins
);

    logic [7:0] r_last_pins;

    // The pin levels reported by the most recently delivered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pins <= cfr_pkg::PIN_RESET;
        end else if (i_res_valid && i_res_ready) begin
            r_last_pins <= i_res_pins;
        end
    end

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_pins)
            && $stable(i_res_status))
        else $error("Result changed while stalled.");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_res_valid)
        else $error("Result valid straight after reset.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx_ready |-> i_res_valid && !i_res_ready)
        else $error("Input held back without a stalled result.");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && i_res_status |-> i_res_pins == r_last_pins)
        else $error("Rejected frame changed the pin levels.");

    a_rx_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rx_valid && !i_rx_ready |=> !i_rx_ready || i_res_ready || !i_res_valid
            || $past(i_res_ready))
        else $error("Input stall persisted without cause.");

endmodule

bind config_frame_receiver_pin_driver_core cfr_checker u_cfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rx_valid   (i_rx.valid),
    .i_rx_ready   (i_rx.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_status (o_res.frame_status),
    .i_res_pins   ({o_res.sync_dir_pin, o_res.sync_sd_pin, o_res.svp_iface,
                    o_res.ttl_switch, o_res.pps_sel, o_res.gnss_sel,
                    o_res.motion_sel, o_res.heading_sel})
);
